### rtl/assert_macros.svh
// Assertion macros for the string matcher RTL.
// Simulation gets concurrent assertions; synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define MPSM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the next cycle
`define MPSM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MPSM_ASSERT_SAME(lbl, ante, cons, msg)
`define MPSM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/mpsm_pkg.sv
// Shared types and codes for the multi-pattern string matcher.
// Used by the controller, the datapath and the top level.
package mpsm_pkg;

    // item kinds carried in s_tuser
    localparam logic [1:0] MODE_PATTERN = 2'd0;
    localparam logic [1:0] MODE_END     = 2'd1;
    localparam logic [1:0] MODE_BUILD   = 2'd2;
    localparam logic [1:0] MODE_TEXT    = 2'd3;

    // controller states, also the datapath operation of that cycle
    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_T0   = 5'd1;
    localparam logic [4:0] ST_T1   = 5'd2;
    localparam logic [4:0] ST_T2   = 5'd3;
    localparam logic [4:0] ST_T3   = 5'd4;
    localparam logic [4:0] ST_TOUT = 5'd5;
    localparam logic [4:0] ST_P0   = 5'd6;
    localparam logic [4:0] ST_P1   = 5'd7;
    localparam logic [4:0] ST_P2   = 5'd8;
    localparam logic [4:0] ST_PA   = 5'd9;
    localparam logic [4:0] ST_PB   = 5'd10;
    localparam logic [4:0] ST_E    = 5'd11;
    localparam logic [4:0] ST_B0   = 5'd12;
    localparam logic [4:0] ST_B1   = 5'd13;
    localparam logic [4:0] ST_B2   = 5'd14;
    localparam logic [4:0] ST_B3   = 5'd15;
    localparam logic [4:0] ST_B4   = 5'd16;
    localparam logic [4:0] ST_B5   = 5'd17;
    localparam logic [4:0] ST_B6   = 5'd18;
    localparam logic [4:0] ST_B7   = 5'd19;
    localparam logic [4:0] ST_B8   = 5'd20;
    localparam logic [4:0] ST_B9   = 5'd21;

    typedef struct packed {
        logic [4:0] op;
        logic       accept;
    } mpsm_cmd_t;

    typedef struct packed {
        logic fc_zero;      // first child of the node read is none
        logic sib_zero;     // next sibling of the node read is none
        logic hit;          // edge byte of the node read equals the key
        logic term_nz;      // node read carries a pattern number
        logic rsuf_none;    // suffix link of the node read is none
        logic psuf_none;    // saved suffix link is none
        logic dropped;      // current pattern is being dropped
        logic node_full;    // node table full
        logic queue_empty;  // breadth-first queue drained
        logic root_fc_zero; // root has no children
        logic out_free;     // result register can take a beat
    } mpsm_sts_t;

endpackage

### rtl/mpsm_ctrl.sv
// Controller state machine of the string matcher.
// Depends on mpsm_pkg; drives the datapath through mpsm_cmd_t.
module mpsm_ctrl
    import mpsm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic [1:0] s_tuser,
    output logic       s_tready,
    input  mpsm_sts_t  sts,
    output mpsm_cmd_t  cmd
);

    logic [4:0] state_reg;
    logic [4:0] state_next;

    assign s_tready   = (state_reg == ST_IDLE);
    assign cmd.op     = state_reg;
    assign cmd.accept = s_tvalid && (state_reg == ST_IDLE);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (s_tuser)
                        MODE_PATTERN: state_next = ST_P0;
                        MODE_END:     state_next = ST_E;
                        MODE_BUILD:   state_next = ST_B0;
                        default:      state_next = ST_T0;
                    endcase
                end
            end
            ST_T0: state_next = ST_T1;
            ST_T1: begin
                if (!sts.fc_zero) state_next = ST_T2;
                else if (sts.rsuf_none) state_next = ST_TOUT;
            end
            ST_T2: begin
                if (sts.hit) state_next = sts.term_nz ? ST_T3 : ST_TOUT;
                else if (sts.sib_zero) state_next = sts.psuf_none ? ST_TOUT : ST_T1;
            end
            ST_T3: state_next = ST_TOUT;
            ST_TOUT: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            ST_P0: state_next = sts.dropped ? ST_IDLE : ST_P1;
            ST_P1: state_next = sts.fc_zero ? ST_PA : ST_P2;
            ST_P2: begin
                if (sts.hit) state_next = ST_IDLE;
                else if (sts.sib_zero) state_next = ST_PA;
            end
            ST_PA: state_next = sts.node_full ? ST_IDLE : ST_PB;
            ST_PB: state_next = ST_IDLE;
            ST_E:  state_next = ST_IDLE;
            ST_B0: state_next = sts.root_fc_zero ? ST_IDLE : ST_B1;
            ST_B1: begin
                if (sts.sib_zero) state_next = ST_B2;
            end
            ST_B2: state_next = sts.queue_empty ? ST_IDLE : ST_B3;
            ST_B3: state_next = ST_B4;
            ST_B4: state_next = sts.fc_zero ? ST_B6 : ST_B5;
            ST_B5: begin
                if (sts.sib_zero) state_next = ST_B6;
            end
            ST_B6: state_next = ST_B7;
            ST_B7: state_next = sts.rsuf_none ? ST_B2 : ST_B8;
            ST_B8: begin
                if (!sts.fc_zero) state_next = ST_B9;
                else if (sts.rsuf_none) state_next = ST_B2;
            end
            ST_B9: begin
                if (sts.hit) state_next = ST_B2;
                else if (sts.sib_zero) state_next = sts.psuf_none ? ST_B2 : ST_B8;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/mpsm_dp.sv
// Datapath of the string matcher: node, pattern and queue memories,
// cursors, counters and the result register. Depends on mpsm_pkg.
module mpsm_dp
    import mpsm_pkg::*;
#(
    parameter int MAX_NODES     = 256,
    parameter int MAX_PATTERNS  = 64,
    parameter int POSITION_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  mpsm_cmd_t   cmd,
    input  logic [7:0]  s_tdata,
    output mpsm_sts_t   sts,
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic        m_tuser,
    output logic [23:0] m_tdata
);

    localparam int NB  = $clog2(MAX_NODES);
    localparam int PNB = $clog2(MAX_PATTERNS + 1);
    localparam int PAB = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
    localparam int PB  = POSITION_BITS;
    localparam int SW  = ((PB > NB) ? PB : NB) + 1;

    // node memories
    logic [7:0]   edge_mem [MAX_NODES];
    logic [NB-1:0] sib_mem [MAX_NODES];
    logic [NB-1:0] fc_mem  [MAX_NODES];
    logic [NB-1:0] par_mem [MAX_NODES];
    logic [NB:0]   suf_mem [MAX_NODES];   // top bit set: no link
    logic [PNB-1:0] term_mem [MAX_NODES];
    logic [NB-1:0] plen_mem [MAX_PATTERNS];
    logic [NB-1:0] q_mem   [MAX_NODES];

    logic [7:0]     rd_edge;
    logic [NB-1:0]  rd_sib, rd_fc_m, rd_par, rd_q, rd_plen;
    logic [NB:0]    rd_suf_m;
    logic [PNB-1:0] rd_term;

    logic [NB-1:0]  raddr, raddr_q;
    logic [PAB-1:0] plen_raddr;
    logic [NB-1:0]  q_raddr, q_waddr;

    logic           fc_we, suf_we, term_we, node_we, plen_we, q_we;
    logic [NB-1:0]  fc_waddr, fc_wdata, suf_waddr, term_waddr, q_wdata;
    logic [NB:0]    suf_wdata;
    logic [PNB-1:0] term_wdata;

    // control and payload registers
    logic [NB:0]    node_count_reg, node_count_next;
    logic [PNB-1:0] pat_count_reg, pat_count_next;
    logic [NB-1:0]  ins_cur_reg, ins_cur_next;
    logic [NB-1:0]  ins_len_reg, ins_len_next;
    logic           drop_reg, drop_next;
    logic [NB-1:0]  match_cur_reg, match_cur_next;
    logic [PB-1:0]  pos_reg, pos_next;
    logic           ovf_reg, ovf_next;
    logic [NB-1:0]  root_fc_reg, root_fc_next;
    logic [7:0]     key_reg, key_next;
    logic [NB-1:0]  fcold_reg, fcold_next;
    logic [NB:0]    psuf_reg, psuf_next;
    logic [NB-1:0]  cur_reg, cur_next;
    logic [NB-1:0]  par_reg, par_next;
    logic [NB-1:0]  head_reg, head_next;
    logic [NB-1:0]  tail_reg, tail_next;
    logic [PNB-1:0] num_reg, num_next;
    logic [15:0]    start_reg, start_next;
    logic           out_valid_reg, out_valid_next;
    logic [23:0]    out_data_reg, out_data_next;
    logic           out_found_reg, out_found_next;

    logic [NB-1:0] fc_eff;
    logic [NB:0]   suf_eff;
    logic [NB-1:0] new_node;
    logic [SW-1:0] pos_w, len_w, start_w;
    logic          out_free;

    localparam logic [NB:0] SUF_NONE = {1'b1, {NB{1'b0}}};

    // root entry lives in flip-flops; address zero reads through them
    assign fc_eff   = (raddr_q == '0) ? root_fc_reg : rd_fc_m;
    assign suf_eff  = (raddr_q == '0) ? SUF_NONE : rd_suf_m;
    assign new_node = node_count_reg[NB-1:0];
    assign out_free = !out_valid_reg || m_tready;

    assign pos_w   = SW'(pos_reg);
    assign len_w   = SW'(rd_plen);
    assign start_w = (len_w > pos_w) ? SW'(1) : (pos_w - len_w + SW'(1));

    // status to the controller
    assign sts.fc_zero      = (fc_eff == '0);
    assign sts.sib_zero     = (rd_sib == '0);
    assign sts.hit          = (rd_edge == key_reg);
    assign sts.term_nz      = (rd_term != '0);
    assign sts.rsuf_none    = suf_eff[NB];
    assign sts.psuf_none    = psuf_reg[NB];
    assign sts.dropped      = drop_reg;
    assign sts.node_full    = (node_count_reg == (NB+1)'(MAX_NODES));
    assign sts.queue_empty  = (head_reg == tail_reg);
    assign sts.root_fc_zero = (root_fc_reg == '0);
    assign sts.out_free     = out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = out_data_reg;

    // per-operation actions
    always_comb begin
        raddr           = raddr_q;
        plen_raddr      = '0;
        q_raddr         = head_reg;
        q_waddr         = tail_reg;
        node_we         = 1'b0;
        fc_we           = 1'b0;
        fc_waddr        = new_node;
        fc_wdata        = '0;
        suf_we          = 1'b0;
        suf_waddr       = new_node;
        suf_wdata       = SUF_NONE;
        term_we         = 1'b0;
        term_waddr      = new_node;
        term_wdata      = '0;
        plen_we         = 1'b0;
        q_we            = 1'b0;
        q_wdata         = '0;
        node_count_next = node_count_reg;
        pat_count_next  = pat_count_reg;
        ins_cur_next    = ins_cur_reg;
        ins_len_next    = ins_len_reg;
        drop_next       = drop_reg;
        match_cur_next  = match_cur_reg;
        pos_next        = pos_reg;
        ovf_next        = ovf_reg;
        root_fc_next    = root_fc_reg;
        key_next        = key_reg;
        fcold_next      = fcold_reg;
        psuf_next       = psuf_reg;
        cur_next        = cur_reg;
        par_next        = par_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        num_next        = num_reg;
        start_next      = start_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_found_next  = out_found_reg;

        if (cmd.accept) begin
            key_next = s_tdata;
        end

        case (cmd.op)
            // text byte: bump position, read the match node
            ST_T0: begin
                if (pos_reg != '1) pos_next = pos_reg + PB'(1);
                raddr      = match_cur_reg;
                num_next   = '0;
                start_next = '0;
            end
            ST_T1: begin
                psuf_next = suf_eff;
                if (fc_eff != '0) raddr = fc_eff;
                else if (suf_eff[NB]) match_cur_next = '0;
                else raddr = suf_eff[NB-1:0];
            end
            ST_T2: begin
                if (rd_edge == key_reg) begin
                    if (rd_term != '0) begin
                        num_next   = rd_term;
                        plen_raddr = PAB'(rd_term - PNB'(1));
                    end else begin
                        match_cur_next = raddr_q;
                    end
                end else if (rd_sib != '0) begin
                    raddr = rd_sib;
                end else if (psuf_reg[NB]) begin
                    match_cur_next = '0;
                end else begin
                    raddr = psuf_reg[NB-1:0];
                end
            end
            ST_T3: begin
                start_next     = 16'(start_w);
                match_cur_next = '0;
            end
            ST_TOUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_found_next = (num_reg != '0);
                    out_data_next  = {ovf_reg, 7'(num_reg), start_reg};
                end
            end
            // pattern byte: look for the child, else allocate
            ST_P0: begin
                raddr = ins_cur_reg;
            end
            ST_P1: begin
                fcold_next = fc_eff;
                if (fc_eff != '0) raddr = fc_eff;
            end
            ST_P2: begin
                if (rd_edge == key_reg) begin
                    ins_cur_next = raddr_q;
                    ins_len_next = ins_len_reg + NB'(1);
                end else if (rd_sib != '0) begin
                    raddr = rd_sib;
                end
            end
            ST_PA: begin
                if (node_count_reg == (NB+1)'(MAX_NODES)) begin
                    ovf_next  = 1'b1;
                    drop_next = 1'b1;
                end else begin
                    node_we = 1'b1;
                    fc_we   = 1'b1;
                    suf_we  = 1'b1;
                    term_we = 1'b1;
                end
            end
            ST_PB: begin
                fc_we    = 1'b1;
                fc_waddr = ins_cur_reg;
                fc_wdata = new_node;
                if (ins_cur_reg == '0) root_fc_next = new_node;
                node_count_next = node_count_reg + (NB+1)'(1);
                ins_cur_next    = new_node;
                ins_len_next    = ins_len_reg + NB'(1);
            end
            // end of pattern
            ST_E: begin
                if (!drop_reg) begin
                    if (pat_count_reg == PNB'(MAX_PATTERNS)) begin
                        ovf_next = 1'b1;
                    end else begin
                        plen_we        = 1'b1;
                        term_we        = 1'b1;
                        term_waddr     = ins_cur_reg;
                        term_wdata     = pat_count_reg + PNB'(1);
                        pat_count_next = pat_count_reg + PNB'(1);
                    end
                end
                ins_cur_next = '0;
                ins_len_next = '0;
                drop_next    = 1'b0;
            end
            // build: queue the root's children, first entry at slot zero
            ST_B0: begin
                head_next = '0;
                tail_next = '0;
                if (root_fc_reg != '0) begin
                    q_we      = 1'b1;
                    q_waddr   = '0;
                    q_wdata   = root_fc_reg;
                    tail_next = NB'(1);
                    raddr     = root_fc_reg;
                end
            end
            ST_B1, ST_B5: begin
                if (rd_sib != '0) begin
                    q_we      = 1'b1;
                    q_wdata   = rd_sib;
                    tail_next = tail_reg + NB'(1);
                    raddr     = rd_sib;
                end
            end
            ST_B2: begin
                q_raddr = head_reg;
                if (head_reg != tail_reg) head_next = head_reg + NB'(1);
            end
            ST_B3: begin
                cur_next = rd_q;
                raddr    = rd_q;
            end
            ST_B4: begin
                key_next = rd_edge;
                par_next = rd_par;
                if (fc_eff != '0) begin
                    q_we      = 1'b1;
                    q_wdata   = fc_eff;
                    tail_next = tail_reg + NB'(1);
                    raddr     = fc_eff;
                end
            end
            ST_B6: begin
                raddr = par_reg;
            end
            ST_B7: begin
                if (suf_eff[NB]) begin
                    suf_we    = 1'b1;
                    suf_waddr = cur_reg;
                    suf_wdata = '0;
                end else begin
                    raddr = suf_eff[NB-1:0];
                end
            end
            ST_B8: begin
                psuf_next = suf_eff;
                if (fc_eff != '0) begin
                    raddr = fc_eff;
                end else if (suf_eff[NB]) begin
                    suf_we    = 1'b1;
                    suf_waddr = cur_reg;
                    suf_wdata = '0;
                end else begin
                    raddr = suf_eff[NB-1:0];
                end
            end
            ST_B9: begin
                if (rd_edge == key_reg) begin
                    suf_we    = 1'b1;
                    suf_waddr = cur_reg;
                    suf_wdata = {1'b0, raddr_q};
                end else if (rd_sib != '0) begin
                    raddr = rd_sib;
                end else if (psuf_reg[NB]) begin
                    suf_we    = 1'b1;
                    suf_waddr = cur_reg;
                    suf_wdata = '0;
                end else begin
                    raddr = psuf_reg[NB-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    // node memories: one write and one registered read each
    always_ff @(posedge aclk) begin
        if (node_we) begin
            edge_mem[new_node] <= key_reg;
            sib_mem[new_node]  <= fcold_reg;
            par_mem[new_node]  <= ins_cur_reg;
        end
        if (fc_we)   fc_mem[fc_waddr]     <= fc_wdata;
        if (suf_we)  suf_mem[suf_waddr]   <= suf_wdata;
        if (term_we) term_mem[term_waddr] <= term_wdata;
        rd_edge  <= edge_mem[raddr];
        rd_sib   <= sib_mem[raddr];
        rd_fc_m  <= fc_mem[raddr];
        rd_par   <= par_mem[raddr];
        rd_suf_m <= suf_mem[raddr];
        rd_term  <= term_mem[raddr];
        raddr_q  <= raddr;
    end

    // pattern length table
    always_ff @(posedge aclk) begin
        if (plen_we) plen_mem[pat_count_reg[PAB-1:0]] <= ins_len_reg;
        rd_plen <= plen_mem[plen_raddr];
    end

    // breadth-first queue
    always_ff @(posedge aclk) begin
        if (q_we) q_mem[q_waddr] <= q_wdata;
        rd_q <= q_mem[q_raddr];
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= (NB+1)'(1);
            pat_count_reg  <= '0;
            ins_cur_reg    <= '0;
            ins_len_reg    <= '0;
            drop_reg       <= 1'b0;
            match_cur_reg  <= '0;
            pos_reg        <= '0;
            ovf_reg        <= 1'b0;
            root_fc_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            node_count_reg <= node_count_next;
            pat_count_reg  <= pat_count_next;
            ins_cur_reg    <= ins_cur_next;
            ins_len_reg    <= ins_len_next;
            drop_reg       <= drop_next;
            match_cur_reg  <= match_cur_next;
            pos_reg        <= pos_next;
            ovf_reg        <= ovf_next;
            root_fc_reg    <= root_fc_next;
            out_valid_reg  <= out_valid_next;
        end
        key_reg       <= key_next;
        fcold_reg     <= fcold_next;
        psuf_reg      <= psuf_next;
        cur_reg       <= cur_next;
        par_reg       <= par_next;
        head_reg      <= head_next;
        tail_reg      <= tail_next;
        num_reg       <= num_next;
        start_reg     <= start_next;
        out_data_reg  <= out_data_next;
        out_found_reg <= out_found_next;
    end

endmodule

### rtl/multi_pattern_string_matcher.sv
// Top level of the multi-pattern string matcher (keyword trie, suffix links).
// Depends on mpsm_pkg, mpsm_ctrl, mpsm_dp and assert_macros.svh.
//
// channel  dir  ports                      beat
// s_       in   tvalid tready tdata tuser  tdata: char_in; tuser: mode
// m_       out  tvalid tready tdata tuser  one per text byte
//
// A pattern byte walks the cursor node's children and allocates a node if none
// matches; an end of pattern stores its number and length; a text byte walks
// children, siblings and suffix links and forms the start of a match; build
// walks the trie breadth first, all through one read port of the node memories.
// Reset is synchronous, active low; no clearing pass is needed.
// A finished result waits in the output register; a new item is taken meanwhile.
`include "assert_macros.svh"
module multi_pattern_string_matcher
    import mpsm_pkg::*;
#(
    parameter int MAX_NODES     = 256,
    parameter int MAX_PATTERNS  = 64,
    parameter int POSITION_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic [1:0]  s_tuser,   // [1:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] start_position, [22:16] pattern_number,
                                   // [23] table_overflow
    output logic        m_tuser    // [0] found
);

    mpsm_cmd_t cmd;
    mpsm_sts_t sts;

    mpsm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mpsm_dp #(
        .MAX_NODES     (MAX_NODES),
        .MAX_PATTERNS  (MAX_PATTERNS),
        .POSITION_BITS (POSITION_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .sts      (sts),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    // checks
    `MPSM_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready while busy")
    `MPSM_ASSERT_SAME(a_nomatch_start, m_tvalid && !m_tuser, m_tdata[15:0] == 16'd0, "start without match")
    `MPSM_ASSERT_NEXT(a_no_result_from_load, s_tvalid && s_tready && s_tuser != MODE_TEXT && !m_tvalid, !m_tvalid, "result from non-text item")

endmodule

### tb/sv/tb_top.sv
// Testbench for multi_pattern_string_matcher: loads keyword sets, builds links,
// streams text bytes and checks each result beat against a built-in trie model.
// Depends on mpsm_pkg and the RTL of the matcher.
module tb_top
    import mpsm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES    = 256;
    localparam int PATTERNS = 64;
    localparam int NONE     = -1;
    localparam int POS_MAX  = 65535;
    localparam int LIMIT    = 10000000;

    typedef struct packed {
        logic        found;
        logic [15:0] start_pos;
        logic [6:0]  pat_num;
        logic        overflow;
    } match_t;

    typedef struct {
        logic [1:0] mode;
        logic [7:0] ch;
        bit         has_exp;
        match_t     exp;
    } row_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [7:0]  s_tdata = 0;
    logic [1:0]  s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [23:0] m_tdata;
    logic        m_tuser;

    multi_pattern_string_matcher i_dut (.*);

    always #2 aclk = ~aclk;

    // trie model state
    logic [7:0] t_char [NODES];
    int t_child [NODES], t_sib [NODES], t_par [NODES], t_suf [NODES], t_term [NODES];
    int p_len [PATTERNS];
    int n_nodes, n_pats, ins_cur, ins_len, m_cur, txt_pos;
    bit ovf, dropped;

    match_t match_q[$];
    int mismatches = 0;
    int cycles = 0;
    bit stim_done = 0;

    function automatic void trie_reset();
        t_child[0] = NONE; t_sib[0] = NONE; t_par[0] = 0; t_suf[0] = NONE;
        t_term[0] = 0;
        n_nodes = 1; n_pats = 0; ins_cur = 0; ins_len = 0; m_cur = 0;
        txt_pos = 0; ovf = 0; dropped = 0;
    endfunction

    function automatic int find_child(int node, logic [7:0] ch);
        int k;
        if (node == NONE || node >= n_nodes) return NONE;
        k = t_child[node];
        while (k != NONE) begin
            if (t_char[k] == ch) return k;
            k = t_sib[k];
        end
        return NONE;
    endfunction

    // Applies one item; returns 1 with the expected beat for text bytes.
    function automatic bit trie_step(logic [1:0] mode, logic [7:0] ch, output match_t r);
        int k, cur, p, q, head, tail, num, len, st;
        int bq[NODES];
        r = '0;
        case (mode)
            MODE_PATTERN: begin
                if (dropped) return 0;
                k = find_child(ins_cur, ch);
                if (k == NONE) begin
                    if (n_nodes >= NODES) begin
                        ovf = 1; dropped = 1; return 0;
                    end
                    k = n_nodes++;
                    t_char[k] = ch; t_child[k] = NONE; t_sib[k] = t_child[ins_cur];
                    t_child[ins_cur] = k; t_par[k] = ins_cur; t_suf[k] = NONE;
                    t_term[k] = 0;
                end
                ins_cur = k; ins_len++;
                return 0;
            end
            MODE_END: begin
                if (!dropped) begin
                    if (n_pats >= PATTERNS) ovf = 1;
                    else begin
                        p_len[n_pats] = ins_len; n_pats++; t_term[ins_cur] = n_pats;
                    end
                end
                ins_cur = 0; ins_len = 0; dropped = 0;
                return 0;
            end
            MODE_BUILD: begin
                head = 0; tail = 0;
                for (k = t_child[0]; k != NONE; k = t_sib[k]) bq[tail++] = k;
                while (head < tail) begin
                    cur = bq[head++];
                    for (k = t_child[cur]; k != NONE; k = t_sib[k]) bq[tail++] = k;
                    p = t_suf[t_par[cur]]; q = NONE;
                    while (p != NONE) begin
                        q = find_child(p, t_char[cur]);
                        if (q != NONE) break;
                        p = t_suf[p];
                    end
                    t_suf[cur] = (p != NONE && q != NONE) ? q : 0;
                end
                return 0;
            end
            default: begin
                if (txt_pos < POS_MAX) txt_pos++;
                cur = m_cur; num = 0; st = 0;
                forever begin
                    k = find_child(cur, ch);
                    if (k != NONE) begin
                        cur = k;
                        if (t_term[k] != 0) begin
                            num = t_term[k]; len = p_len[num-1];
                            st = (len > txt_pos) ? 1 : txt_pos - len + 1;
                            cur = 0;
                        end
                        break;
                    end
                    cur = t_suf[cur];
                    if (cur == NONE) begin
                        cur = 0; break;
                    end
                end
                m_cur = cur;
                r.found = (num != 0); r.start_pos = 16'(st); r.pat_num = 7'(num);
                r.overflow = ovf;
                return 1;
            end
        endcase
    endfunction

    // stimulus
    row_t rows[$];
    bit   hold_off = 0;

    function automatic void add_row(logic [1:0] m, logic [7:0] c, bit he = 0,
                                    match_t e = '0);
        row_t r;
        r.mode = m; r.ch = c; r.has_exp = he; r.exp = e;
        rows.insert(rows.size(), r);
    endfunction

    function automatic void add_word(string w);
        foreach (w[i]) add_row(MODE_PATTERN, w[i]);
        add_row(MODE_END, 8'h00);
    endfunction

    // random alphabet kept small so matches happen; some full-range bytes too
    function automatic logic [7:0] rnd_byte();
        if ($urandom_range(0, 9) == 0) return 8'($urandom);
        return 8'($urandom_range(8'h61, 8'h64)) ^ ($urandom_range(0, 3) == 0 ? 8'h80 : 8'h00);
    endfunction

    task automatic send(row_t r);
        match_t e;
        bit     got;
        s_tvalid <= 1; s_tuser <= r.mode; s_tdata <= r.ch;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        got = trie_step(r.mode, r.ch, e);
        if (got) begin
            if (r.has_exp && e != r.exp) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("table row disagrees with model: exp %h got %h", r.exp, e);
            end
            match_q.insert(match_q.size(), r.has_exp ? r.exp : e);
        end
        @(negedge aclk);
        // burst gaps
        if ($urandom_range(0, 3) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
    endtask

    initial begin
        row_t r;
        int   n, len, i;
        trie_reset();
        // directed: text before any pattern, then extremes and special cases
        add_row(MODE_TEXT, 8'h00, 1, '0);
        add_row(MODE_TEXT, 8'hFF, 1, '0);
        add_row(MODE_END, 8'h00);                     // empty pattern is #1
        add_row(MODE_PATTERN, 8'hFF); add_row(MODE_END, 8'h00);    // #2
        add_row(MODE_PATTERN, 8'h00); add_row(MODE_END, 8'h00);    // #3
        add_row(MODE_TEXT, 8'hFF, 1, '{1'b1, 16'd3, 7'd2, 1'b0});  // no links yet
        add_word("ab"); add_word("b"); add_word("ab");             // duplicate
        add_row(MODE_BUILD, 8'h00);
        add_row(MODE_TEXT, 8'h00, 1, '{1'b1, 16'd4, 7'd3, 1'b0});
        add_row(MODE_TEXT, "a"); add_row(MODE_TEXT, "b");
        add_row(MODE_TEXT, "a"); add_row(MODE_TEXT, "x"); add_row(MODE_TEXT, "b");
        // start driving only once reset is released
        wait (aresetn);
        @(negedge aclk);
        foreach (rows[k]) send(rows[k]);
        rows.delete();

        // random: well-formed patterns, builds, long patterns and text runs in random order
        for (n = 0; n < 1550; ) begin
            if (n > 700 && !hold_off) begin
                hold_off = 1;
                s_tvalid <= 0;
                while (match_q.size() != 0) @(negedge aclk);
            end
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    len = $urandom_range(0, 4);
                    for (i = 0; i < len; i++) begin
                        r.mode = MODE_PATTERN; r.ch = rnd_byte(); r.has_exp = 0;
                        send(r); n++;
                    end
                    r.mode = MODE_END; send(r); n++;
                end
                3: begin
                    r.mode = MODE_BUILD; r.ch = 8'($urandom); r.has_exp = 0; send(r); n++;
                end
                4: begin
                    // long pattern to push the node table toward overflow
                    for (i = 0; i < 30; i++) begin
                        r.mode = MODE_PATTERN; r.ch = 8'($urandom); r.has_exp = 0;
                        send(r); n++;
                    end
                    r.mode = MODE_END; send(r); n++;
                end
                default: begin
                    for (i = $urandom_range(1, 20); i > 0; i--) begin
                        r.mode = MODE_TEXT; r.ch = rnd_byte(); r.has_exp = 0;
                        send(r); n++;
                    end
                end
            endcase
        end
        s_tvalid <= 0;
        stim_done = 1;
    end

    // receiver stall pattern and reset
    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1;
        forever begin
            @(negedge aclk);
            if (cycles % 512 < 128) m_tready <= 1;
            else m_tready <= ($urandom_range(0, 2) != 0);
        end
    end

    // check result beats
    always @(posedge aclk) begin
        match_t got, e;
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata[15:0], m_tdata[22:16], m_tdata[23]};
            if (match_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat %h", got);
            end else begin
                e = match_q.pop_front();
                if (got != e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: found %b/%b start %0d/%0d pat %0d/%0d ovf %b/%b",
                                 e.found, got.found, e.start_pos, got.start_pos,
                                 e.pat_num, got.pat_num, e.overflow, got.overflow);
                end
            end
        end
    end

    // end of run and timeout
    initial begin
        fork
            begin
                wait (stim_done);
                while (match_q.size() != 0) @(posedge aclk);
                repeat (200) @(posedge aclk);
            end
            begin
                while (cycles < LIMIT) @(posedge aclk);
                mismatches++;
                $display("timeout");
            end
        join_any
        if (mismatches == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule

### sim.f
+incdir+rtl
rtl/mpsm_pkg.sv
rtl/mpsm_ctrl.sv
rtl/mpsm_dp.sv
rtl/multi_pattern_string_matcher.sv
tb/sv/tb_top.sv
